/* design/bis_pkg.sv */
`timescale 1ns / 1ps
// Package for the bilinear image sampler: operation and register codes,
// bank layout constants and the command flag type shared by the front, the back and the top level.
// Depends on nothing.
package bis_pkg;

  // Operation codes of an input beat.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_COLS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_ROWS = 2'd1;

  // Configuration register layout and reset values.
  localparam int REG_W = 9;
  localparam logic [REG_W-1:0] IMAGE_COLS_RST = 9'd256;
  localparam logic [REG_W-1:0] IMAGE_ROWS_RST = 9'd256;

  // Fixed field widths.
  localparam int PIX_W   = 16;
  localparam int COORD_W = 16;
  localparam int IDX_W   = 8;
  // Coordinate integer parts are compared in this width so that the
  // increment never wraps.
  localparam int CMP_W   = COORD_W + 1;

  // The store is split into four banks by row and column parity.
  localparam int NUM_BANKS = 4;
  localparam int BANK_W    = 2;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic is_sample;
    logic oor;
  } cmd_flags_t;

endpackage

/* design/bilinear_image_sampler.sv */
`timescale 1ns / 1ps
// Top level of the bilinear image sampler: front, command queue and back.
// Depends on bis_pkg, bis_front, bis_queue and bis_back.

// The sampler holds one single-channel image of signed 16-bit pixels and
// streams one beat per clock while the command queue has room. A write beat
// (op 0) stores one pixel and gives no result; a write outside the
// MAX_ROWS x MAX_COLS store is dropped. A sample beat (op 1) takes
// Q.FRAC_BITS coordinates and returns one result: the bilinear blend of the
// 2x2 neighbourhood, rounded half up, or zero with the off-image flag set
// when the neighbourhood leaves the image set by the image_cols and
// image_rows registers. The block accepts one beat per cycle while the
// command queue is not full; a sample passes through the queue, the store
// read, the vertical products, the column sums, the horizontal products and
// the rounding into the output register. That rate comes from splitting the
// store into four banks by row and column parity, so the four neighbours of
// any cell are read together through one port per bank. Store contents are
// undefined until written; there is no clearing pass after reset. Write the
// configuration registers only while the block is idle.
module bilinear_image_sampler import bis_pkg::*; #(
  parameter int MAX_COLS  = 256,
  parameter int MAX_ROWS  = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [REG_IDX_W-1:0]    cfg_index,
  input  logic [REG_W-1:0]        cfg_data,
  // input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_op,
  input  logic [IDX_W-1:0]        in_pixel_col,
  input  logic [IDX_W-1:0]        in_pixel_row,
  input  logic signed [PIX_W-1:0] in_pixel_value,
  input  logic [COORD_W-1:0]      in_coord_u,
  input  logic [COORD_W-1:0]      in_coord_v,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [PIX_W-1:0] out_sample_value,
  output logic                    out_off_image
);

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  // Flags, row, column, two fractions and the write data travel together.
  localparam int CMD_W = $bits(cmd_flags_t) + ROW_W + COL_W + 2 * FRAC_BITS + PIX_W;

  // Front side command.
  logic                 f_push;
  cmd_flags_t           f_flags;
  logic [ROW_W-1:0]     f_row;
  logic [COL_W-1:0]     f_col;
  logic [FRAC_BITS-1:0] f_dx, f_dy;
  logic [PIX_W-1:0]     f_wdata;

  // Back side command.
  cmd_flags_t           b_flags;
  logic [ROW_W-1:0]     b_row;
  logic [COL_W-1:0]     b_col;
  logic [FRAC_BITS-1:0] b_dx, b_dy;
  logic [PIX_W-1:0]     b_wdata;

  logic             q_full, q_not_empty, q_pop;
  logic [CMD_W-1:0] q_in, q_out;

  // The front decodes each beat, checks the range and drops writes that
  // miss the store. It stalls only when the queue is full.
  bis_front #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_pixel_col   (in_pixel_col),
    .in_pixel_row   (in_pixel_row),
    .in_pixel_value (in_pixel_value),
    .in_coord_u     (in_coord_u),
    .in_coord_v     (in_coord_v),
    .q_full         (q_full),
    .cmd_push       (f_push),
    .cmd_flags      (f_flags),
    .cmd_row        (f_row),
    .cmd_col        (f_col),
    .cmd_dx         (f_dx),
    .cmd_dy         (f_dy),
    .cmd_wdata      (f_wdata)
  );

  assign q_in = {f_flags, f_row, f_col, f_dx, f_dy, f_wdata};

  // The queue decouples the front from the back so that a stall on the
  // result side does not reach the input within the same cycle.
  bis_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_not_empty)
  );

  assign {b_flags, b_row, b_col, b_dx, b_dy, b_wdata} = q_out;

  // The back owns the banked store and the blend pipeline; it advances as a
  // whole whenever the output register is free or being taken.
  bis_back #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_pop            (q_pop),
    .cmd_flags        (b_flags),
    .cmd_row          (b_row),
    .cmd_col          (b_col),
    .cmd_dx           (b_dx),
    .cmd_dy           (b_dy),
    .cmd_wdata        (b_wdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_value (out_sample_value),
    .out_off_image    (out_off_image)
  );

endmodule

/* design/bis_queue.sv */
`timescale 1ns / 1ps
// Small command queue that decouples the front from the back.
// Depends on nothing but its parameters.
module bis_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* design/bis_front.sv */
`timescale 1ns / 1ps
// Front of the bilinear image sampler: configuration registers, input
// decode, range check and command generation. Depends on bis_pkg.
module bis_front import bis_pkg::*; #(
  parameter int MAX_COLS  = 256,
  parameter int MAX_ROWS  = 256,
  parameter int FRAC_BITS = 8,
  localparam int COL_W    = $clog2(MAX_COLS),
  localparam int ROW_W    = $clog2(MAX_ROWS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  // input beats
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [IDX_W-1:0]     in_pixel_col,
  input  logic [IDX_W-1:0]     in_pixel_row,
  input  logic signed [PIX_W-1:0] in_pixel_value,
  input  logic [COORD_W-1:0]   in_coord_u,
  input  logic [COORD_W-1:0]   in_coord_v,
  // command toward the queue
  input  logic                 q_full,
  output logic                 cmd_push,
  output cmd_flags_t           cmd_flags,
  output logic [ROW_W-1:0]     cmd_row,
  output logic [COL_W-1:0]     cmd_col,
  output logic [FRAC_BITS-1:0] cmd_dx,
  output logic [FRAC_BITS-1:0] cmd_dy,
  output logic [PIX_W-1:0]     cmd_wdata
);

  logic [REG_W-1:0] cols_r;
  logic [REG_W-1:0] rows_r;

  logic [CMP_W-1:0] cols_eff, rows_eff;
  logic [CMP_W-1:0] ix_x, iy_x, pcol_x, prow_x;
  logic             in_store;
  logic             sample_oor;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= IMAGE_COLS_RST;
      rows_r <= IMAGE_ROWS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_COLS: cols_r <= cfg_data;
        REG_IMAGE_ROWS: rows_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sizes above the store count as the store size.
  assign cols_eff = (CMP_W'(cols_r) > CMP_W'(MAX_COLS)) ? CMP_W'(MAX_COLS) : CMP_W'(cols_r);
  assign rows_eff = (CMP_W'(rows_r) > CMP_W'(MAX_ROWS)) ? CMP_W'(MAX_ROWS) : CMP_W'(rows_r);

  assign ix_x   = CMP_W'(in_coord_u >> FRAC_BITS);
  assign iy_x   = CMP_W'(in_coord_v >> FRAC_BITS);
  assign pcol_x = CMP_W'(in_pixel_col);
  assign prow_x = CMP_W'(in_pixel_row);

  assign sample_oor = (ix_x + CMP_W'(1) >= cols_eff) || (iy_x + CMP_W'(1) >= rows_eff);
  assign in_store   = (pcol_x < CMP_W'(MAX_COLS)) && (prow_x < CMP_W'(MAX_ROWS));

  assign in_ready = !q_full;

  // Writes that fall outside the store are accepted and dropped here.
  always_comb begin
    cmd_flags.is_sample = (in_op == OP_SAMPLE);
    cmd_flags.oor       = sample_oor;
    cmd_push            = in_valid && !q_full && ((in_op == OP_SAMPLE) || in_store);
    if (in_op == OP_SAMPLE) begin
      cmd_row = iy_x[ROW_W-1:0];
      cmd_col = ix_x[COL_W-1:0];
    end else begin
      cmd_row = prow_x[ROW_W-1:0];
      cmd_col = pcol_x[COL_W-1:0];
    end
    cmd_dx    = in_coord_u[FRAC_BITS-1:0];
    cmd_dy    = in_coord_v[FRAC_BITS-1:0];
    cmd_wdata = in_pixel_value;
  end

endmodule

/* design/bis_back.sv */
`timescale 1ns / 1ps
// Back of the bilinear image sampler: four parity banks of the image store
// and the blend pipeline up to the output register. Depends on bis_pkg.
module bis_back import bis_pkg::*; #(
  parameter int MAX_COLS  = 256,
  parameter int MAX_ROWS  = 256,
  parameter int FRAC_BITS = 8,
  localparam int COL_W    = $clog2(MAX_COLS),
  localparam int ROW_W    = $clog2(MAX_ROWS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // command from the queue
  input  logic                 q_not_empty,
  output logic                 q_pop,
  input  cmd_flags_t           cmd_flags,
  input  logic [ROW_W-1:0]     cmd_row,
  input  logic [COL_W-1:0]     cmd_col,
  input  logic [FRAC_BITS-1:0] cmd_dx,
  input  logic [FRAC_BITS-1:0] cmd_dy,
  input  logic [PIX_W-1:0]     cmd_wdata,
  // results
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [PIX_W-1:0] out_sample_value,
  output logic                 out_off_image
);

  localparam int RH_W   = (ROW_W > 1) ? ROW_W - 1 : 1;
  localparam int CH_W   = (COL_W > 1) ? COL_W - 1 : 1;
  localparam int ADDR_W = RH_W + CH_W;
  localparam int BANK_D = 2 ** ADDR_W;
  localparam int W_W    = FRAC_BITS + 1;
  localparam int P_W    = PIX_W + W_W + 1;
  localparam int Q_W    = P_W + W_W + 1;
  localparam logic [W_W-1:0] S_VAL = W_W'(1) << FRAC_BITS;
  localparam logic signed [Q_W-1:0] HALF = Q_W'(1) << (2 * FRAC_BITS - 1);

  logic en;
  logic do_wr, do_rd;

  logic [BANK_W-1:0] wr_bank;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr [NUM_BANKS];
  logic [NUM_BANKS-1:0] bank_we, bank_re;
  logic [PIX_W-1:0]  bank_q [NUM_BANKS];
  logic [ROW_W:0]    r_sel [NUM_BANKS];
  logic [COL_W:0]    c_sel [NUM_BANKS];

  // stage 1: bank read data
  logic                 s1_valid_r, s1_oor_r, s1_rpar_r, s1_cpar_r;
  logic [FRAC_BITS-1:0] s1_dx_r, s1_dy_r;
  // stage 2: vertical products
  logic                 s2_valid_r, s2_oor_r;
  logic [FRAC_BITS-1:0] s2_dx_r;
  logic signed [P_W-1:0] s2_a_r, s2_b_r, s2_c_r, s2_d_r;
  // stage 3: column sums
  logic                 s3_valid_r, s3_oor_r;
  logic [FRAC_BITS-1:0] s3_dx_r;
  logic signed [P_W-1:0] s3_left_r, s3_right_r;
  // stage 4: horizontal products
  logic                 s4_valid_r, s4_oor_r;
  logic signed [Q_W-1:0] s4_m0_r, s4_m1_r;
  // output register
  logic                 out_valid_r;
  logic                 out_oor_r;
  logic signed [PIX_W-1:0] out_value_r;

  logic signed [PIX_W-1:0] p00, p01, p10, p11;
  logic signed [W_W:0]  wy0, wy1, wx0, wx1;
  logic signed [P_W-1:0] prod_a, prod_b, prod_c, prod_d;
  logic signed [Q_W-1:0] mul_0, mul_1, acc_rnd;
  logic signed [PIX_W-1:0] value_rnd;

  // The whole back pipeline advances together when the output can move.
  assign en    = !out_valid_r || out_ready;
  assign q_pop = en;
  assign do_wr = en && q_not_empty && !cmd_flags.is_sample;
  assign do_rd = en && q_not_empty && cmd_flags.is_sample && !cmd_flags.oor;

  assign wr_bank = {cmd_row[0], cmd_col[0]};
  assign wr_addr = {RH_W'(cmd_row >> 1), CH_W'(cmd_col >> 1)};

  // Each bank holds one of the four neighbours: pick row or row+1 and col or
  // col+1 according to the bank's parity.
  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      r_sel[b] = (cmd_row[0] == b[1]) ? {1'b0, cmd_row} : {1'b0, cmd_row} + 1'b1;
      c_sel[b] = (cmd_col[0] == b[0]) ? {1'b0, cmd_col} : {1'b0, cmd_col} + 1'b1;
      rd_addr[b] = {RH_W'(r_sel[b] >> 1), CH_W'(c_sel[b] >> 1)};
      bank_we[b] = do_wr && (wr_bank == BANK_W'(b));
      bank_re[b] = do_rd;
    end
  end

  for (genvar gb = 0; gb < NUM_BANKS; gb++) begin : g_bank
    logic [PIX_W-1:0] mem [BANK_D];
    logic [PIX_W-1:0] q_r;
    always_ff @(posedge clk) begin
      if (bank_we[gb]) begin
        mem[wr_addr] <= cmd_wdata;
      end
      if (bank_re[gb]) begin
        q_r <= mem[rd_addr[gb]];
      end
    end
    assign bank_q[gb] = q_r;
  end

  // Put the bank outputs back into image order.
  assign p00 = bank_q[{s1_rpar_r, s1_cpar_r}];
  assign p01 = bank_q[{s1_rpar_r, ~s1_cpar_r}];
  assign p10 = bank_q[{~s1_rpar_r, s1_cpar_r}];
  assign p11 = bank_q[{~s1_rpar_r, ~s1_cpar_r}];

  assign wy0 = signed'({1'b0, S_VAL - W_W'(s1_dy_r)});
  assign wy1 = signed'({1'b0, W_W'(s1_dy_r)});
  assign wx0 = signed'({1'b0, S_VAL - W_W'(s3_dx_r)});
  assign wx1 = signed'({1'b0, W_W'(s3_dx_r)});

  assign prod_a = p00 * wy0;
  assign prod_b = p10 * wy1;
  assign prod_c = p01 * wy0;
  assign prod_d = p11 * wy1;

  assign mul_0 = s3_left_r * wx0;
  assign mul_1 = s3_right_r * wx1;

  assign acc_rnd   = s4_m0_r + s4_m1_r + HALF;
  assign value_rnd = PIX_W'(acc_rnd >>> (2 * FRAC_BITS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= q_not_empty && cmd_flags.is_sample;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_oor_r   <= cmd_flags.oor;
      s1_rpar_r  <= cmd_row[0];
      s1_cpar_r  <= cmd_col[0];
      s1_dx_r    <= cmd_dx;
      s1_dy_r    <= cmd_dy;
      s2_oor_r   <= s1_oor_r;
      s2_dx_r    <= s1_dx_r;
      s2_a_r     <= prod_a;
      s2_b_r     <= prod_b;
      s2_c_r     <= prod_c;
      s2_d_r     <= prod_d;
      s3_oor_r   <= s2_oor_r;
      s3_dx_r    <= s2_dx_r;
      s3_left_r  <= s2_a_r + s2_b_r;
      s3_right_r <= s2_c_r + s2_d_r;
      s4_oor_r   <= s3_oor_r;
      s4_m0_r    <= mul_0;
      s4_m1_r    <= mul_1;
      out_oor_r  <= s4_oor_r;
      out_value_r <= s4_oor_r ? '0 : value_rnd;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;
  assign out_off_image    = out_oor_r;

  // A write beat touches exactly one bank.
  a_one_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(bank_we))
    else $error("more than one bank written in a cycle");

  // A beat either writes or reads the store, never both.
  a_wr_rd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !((|bank_we) && (|bank_re)))
    else $error("store written and read by the same beat");

  // While the output is stalled the pipeline holds its contents.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s4_valid_r) && $stable(out_oor_r) && $stable(out_value_r))
    else $error("pipeline moved during an output stall");

  // An off-image result always carries a zero value.
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_oor_r) |-> (out_value_r == '0))
    else $error("off-image result with a nonzero value");

endmodule

/* tb/bis_sample_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the bilinear image sampler: keeps its own copy of the image
// and the size registers, predicts every sample beat and compares results.
// Depends on bis_pkg.
module bis_sample_checker import bis_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [REG_IDX_W-1:0]    cfg_index,
  input  logic [REG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    in_op,
  input  logic [IDX_W-1:0]        in_pixel_col,
  input  logic [IDX_W-1:0]        in_pixel_row,
  input  logic signed [PIX_W-1:0] in_pixel_value,
  input  logic [COORD_W-1:0]      in_coord_u,
  input  logic [COORD_W-1:0]      in_coord_v,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [PIX_W-1:0] out_sample_value,
  input  logic                    out_off_image,
  output int                      fail_count,
  output int                      pending_results
);

  localparam int     FRAC  = 8;
  localparam int     CELLS = 256;
  localparam longint SCALE = longint'(1) << FRAC;
  localparam longint HALF  = longint'(1) << (2 * FRAC - 1);

  typedef struct packed {
    logic signed [PIX_W-1:0] value;
    logic                    oor;
  } sample_res_t;

  logic signed [PIX_W-1:0] image_copy [0:CELLS*CELLS-1];
  logic [REG_W-1:0]        cols_reg = IMAGE_COLS_RST;
  logic [REG_W-1:0]        rows_reg = IMAGE_ROWS_RST;
  sample_res_t             expected_samples [$];
  sample_res_t             head;
  int                      mismatches = 0;
  int                      queued = 0;

  assign fail_count      = mismatches;
  assign pending_results = queued;

  // Blend the 2x2 neighbourhood along rows, then columns, and round half up.
  function automatic sample_res_t bilinear_blend(input logic [COORD_W-1:0] u,
                                                 input logic [COORD_W-1:0] v);
    int unsigned ix, iy, cols, rows;
    longint      dx, dy, p00, p01, p10, p11, left, right, acc, scaled;
    sample_res_t res;
    ix   = u >> FRAC;
    iy   = v >> FRAC;
    dx   = u[FRAC-1:0];
    dy   = v[FRAC-1:0];
    cols = (cols_reg > CELLS) ? CELLS : cols_reg;
    rows = (rows_reg > CELLS) ? CELLS : rows_reg;
    res.value = '0;
    res.oor   = 1'b1;
    if (ix + 1 < cols && iy + 1 < rows) begin
      p00    = image_copy[iy * CELLS + ix];
      p01    = image_copy[iy * CELLS + ix + 1];
      p10    = image_copy[(iy + 1) * CELLS + ix];
      p11    = image_copy[(iy + 1) * CELLS + ix + 1];
      left   = p00 * (SCALE - dy) + p10 * dy;
      right  = p01 * (SCALE - dy) + p11 * dy;
      acc    = left * (SCALE - dx) + right * dx;
      scaled = (acc + HALF) >>> (2 * FRAC);
      res.value = scaled[PIX_W-1:0];
      res.oor   = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cols_reg = IMAGE_COLS_RST;
      rows_reg = IMAGE_ROWS_RST;
      expected_samples.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_COLS: cols_reg = cfg_data;
          REG_IMAGE_ROWS: rows_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_op == OP_WRITE) begin
          image_copy[{in_pixel_row, in_pixel_col}] = in_pixel_value;
        end else begin
          expected_samples.push_back(bilinear_blend(in_coord_u, in_coord_v));
        end
      end
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, expected none, got value %0d flag %0b",
                   $time, out_sample_value, out_off_image);
        end else begin
          head = expected_samples.pop_front();
          if (out_sample_value !== head.value) begin
            mismatches++;
            $display("%0t: sample_value mismatch, expected %0d, got %0d",
                     $time, head.value, out_sample_value);
          end
          if (out_off_image !== head.oor) begin
            mismatches++;
            $display("%0t: off_image mismatch, expected %0b, got %0b",
                     $time, head.oor, out_off_image);
          end
        end
      end
    end
    queued = expected_samples.size();
  end

endmodule

/* tb/bilinear_image_sampler_test.sv */
`timescale 1ns / 1ps
// Top of the bilinear image sampler testbench: clock, reset, stimulus, idling
// and the verdict. Depends on bis_pkg, bilinear_image_sampler and
// bis_sample_checker.
module bilinear_image_sampler_test;
  import bis_pkg::*;

  localparam int FRAC         = 8;
  localparam int RESET_CYCLES = 6;
  // Writes give no result, so this many quiet cycles let a trailing write
  // land before a register write or the end of the run.
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int NUM_PHASES   = 10;
  localparam int PHASE_BEATS  = 94;

  // Indexes that map to no register; writes to them must change nothing.
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_2 = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_3 = 2'd3;

  logic                    clk;
  logic                    rst_n            = 1'b0;
  logic                    cfg_valid        = 1'b0;
  logic                    cfg_ready;
  logic [REG_IDX_W-1:0]    cfg_index        = '0;
  logic [REG_W-1:0]        cfg_data         = '0;
  logic                    in_valid         = 1'b0;
  logic                    in_ready;
  logic                    in_op            = OP_WRITE;
  logic [IDX_W-1:0]        in_pixel_col     = '0;
  logic [IDX_W-1:0]        in_pixel_row     = '0;
  logic signed [PIX_W-1:0] in_pixel_value   = '0;
  logic [COORD_W-1:0]      in_coord_u       = '0;
  logic [COORD_W-1:0]      in_coord_v       = '0;
  logic                    out_valid;
  logic                    out_ready        = 1'b0;
  logic signed [PIX_W-1:0] out_sample_value;
  logic                    out_off_image;

  int fail_count;
  int pending_results;

  // The stimulus side tracks which store entries hold a value, because the
  // store is undefined until written and no sample may touch such an entry.
  bit          px_written [0:255][0:255];
  logic [REG_W-1:0] cols_view = IMAGE_COLS_RST;
  logic [REG_W-1:0] rows_view = IMAGE_ROWS_RST;
  bit          tx_idle_en   = 1'b0;
  bit          rx_idle_en   = 1'b0;
  int unsigned rx_stall_left = 0;
  int          beats_sent   = 0;
  int          samples_sent = 0;
  int          inside_sent  = 0;
  int          cfg_writes   = 0;
  int          cycle_count  = 0;

  bilinear_image_sampler i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_pixel_col     (in_pixel_col),
    .in_pixel_row     (in_pixel_row),
    .in_pixel_value   (in_pixel_value),
    .in_coord_u       (in_coord_u),
    .in_coord_v       (in_coord_v),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_value (out_sample_value),
    .out_off_image    (out_off_image)
  );

  bis_sample_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_pixel_col     (in_pixel_col),
    .in_pixel_row     (in_pixel_row),
    .in_pixel_value   (in_pixel_value),
    .in_coord_u       (in_coord_u),
    .in_coord_v       (in_coord_v),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_value (out_sample_value),
    .out_off_image    (out_off_image),
    .fail_count       (fail_count),
    .pending_results  (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The result side stalls in bursts of random length while idling is on.
  // The burst length is kept in a blocking counter so that out_ready gets
  // exactly one nonblocking update per edge.
  always @(posedge clk) begin
    if (rx_stall_left == 0 && rx_idle_en && $urandom_range(9, 0) == 0)
      rx_stall_left = $urandom_range(17, 1);
    if (rx_stall_left != 0) begin
      rx_stall_left = rx_stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Sizes above the store count as the store size.
  function automatic int unsigned clamp_dim(input logic [REG_W-1:0] size);
    return (size > 256) ? 256 : size;
  endfunction

  // Pixel values lean on both extremes so that the blend is pushed to its
  // widest products.
  function automatic logic signed [PIX_W-1:0] rand_pixel();
    case ($urandom_range(7, 0))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return PIX_W'($urandom_range(16'hFFFF, 0));
    endcase
  endfunction

  // Fractions favor zero, exactly one half and the largest step.
  function automatic logic [FRAC-1:0] rand_frac();
    case ($urandom_range(7, 0))
      0: return 8'h00;
      1: return 8'h80;
      2: return 8'hFF;
      default: return FRAC'($urandom_range(255, 0));
    endcase
  endfunction

  // Drives one input beat and holds it until it is taken. A gap before the
  // beat lowers valid first; with no gap valid simply stays high, so it never
  // gets two updates in one time step.
  task automatic send_beat(input logic op, input logic [IDX_W-1:0] col,
                           input logic [IDX_W-1:0] row,
                           input logic signed [PIX_W-1:0] value,
                           input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
    int unsigned gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(4, 0) == 0)
      gap = $urandom_range(17, 1);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_pixel_col   <= col;
    in_pixel_row   <= row;
    in_pixel_value <= value;
    in_coord_u     <= u;
    in_coord_v     <= v;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // The coordinate fields are don't-care on a write beat, so they carry noise.
  task automatic write_pixel(input int unsigned row, input int unsigned col,
                             input logic signed [PIX_W-1:0] value);
    send_beat(OP_WRITE, col[IDX_W-1:0], row[IDX_W-1:0], value,
              COORD_W'($urandom_range(16'hFFFF, 0)), COORD_W'($urandom_range(16'hFFFF, 0)));
    px_written[row[7:0]][col[7:0]] = 1'b1;
  endtask

  // A sample inside the image first fills any of its four neighbors that
  // were never written; a sample outside reads nothing.
  task automatic sample_at(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
    int unsigned ix, iy;
    ix = u >> FRAC;
    iy = v >> FRAC;
    if (ix + 1 < clamp_dim(cols_view) && iy + 1 < clamp_dim(rows_view)) begin
      for (int dr = 0; dr < 2; dr++)
        for (int dc = 0; dc < 2; dc++)
          if (!px_written[iy + dr][ix + dc])
            write_pixel(iy + dr, ix + dc, rand_pixel());
      inside_sent++;
    end
    send_beat(OP_SAMPLE, IDX_W'($urandom_range(255, 0)), IDX_W'($urandom_range(255, 0)),
              rand_pixel(), u, v);
    samples_sent++;
  endtask

  // One register write; valid drops for a cycle afterwards so that a second
  // write never raises it in the step where it was lowered.
  task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    if (idx == REG_IMAGE_COLS)
      cols_view = data;
    else if (idx == REG_IMAGE_ROWS)
      rows_view = data;
    @(posedge clk);
  endtask

  // Brings the block to idle: every expected result in, then a quiet stretch
  // for any write still moving through the pipeline.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register setting followed by random traffic. Most samples land in a
  // small window so that written pixels are reused and overwritten; the rest
  // go anywhere in the image, or are plain noise that is mostly outside it.
  task automatic run_phase(input logic [REG_W-1:0] cols, input logic [REG_W-1:0] rows,
                           input bit idle, input int beats);
    int unsigned cols_eff, rows_eff, wx, wy, ix, iy, pick;
    int          stop_at;
    drain_results();
    set_reg($urandom_range(1, 0) ? REG_UNMAPPED_2 : REG_UNMAPPED_3,
            REG_W'($urandom_range(511, 0)));
    set_reg(REG_IMAGE_COLS, cols);
    set_reg(REG_IMAGE_ROWS, rows);
    tx_idle_en = idle;
    rx_idle_en = idle;
    cols_eff = clamp_dim(cols);
    rows_eff = clamp_dim(rows);
    wx = (cols_eff >= 2) ? $urandom_range(cols_eff - 2, 0) : 0;
    wy = (rows_eff >= 2) ? $urandom_range(rows_eff - 2, 0) : 0;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(99, 0);
      if (pick < 70 && cols_eff >= 2 && rows_eff >= 2) begin
        if (pick < 55) begin
          ix = wx + $urandom_range(2, 0);
          iy = wy + $urandom_range(2, 0);
          if (ix > cols_eff - 2) ix = cols_eff - 2;
          if (iy > rows_eff - 2) iy = rows_eff - 2;
        end else begin
          ix = $urandom_range(cols_eff - 2, 0);
          iy = $urandom_range(rows_eff - 2, 0);
        end
        sample_at({ix[7:0], rand_frac()}, {iy[7:0], rand_frac()});
      end else if (pick < 85) begin
        // Overwrites inside the window change what later samples see;
        // writes anywhere else also hit rows and columns outside the image.
        if ($urandom_range(1, 0) == 0)
          write_pixel(wy + $urandom_range(1, 0), wx + $urandom_range(1, 0), rand_pixel());
        else
          write_pixel($urandom_range(255, 0), $urandom_range(255, 0), rand_pixel());
      end else begin
        sample_at(COORD_W'($urandom_range(16'hFFFF, 0)), COORD_W'($urandom_range(16'hFFFF, 0)));
      end
    end
  endtask

  // Register settings per phase: the reset size, the smallest image, odd
  // sizes, sizes past the store that must clamp, sizes below two where every
  // sample is outside, one-pixel-wide strips, two random sizes and finally
  // the full store again. Phase 6 and the last phase run without idling.
  logic [REG_W-1:0] phase_cols [NUM_PHASES] = '{256, 2, 17, 511, 0, 2, 256, 0, 0, 256};
  logic [REG_W-1:0] phase_rows [NUM_PHASES] = '{256, 2, 5, 300, 1, 256, 2, 0, 0, 256};
  bit               phase_idle [NUM_PHASES] = '{1, 1, 1, 1, 1, 1, 0, 1, 1, 0};

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    // Directed part under the reset size. The top-left cell holds both
    // extremes in a checkerboard, so the center and the half-step points
    // test rounding at exactly one half, and full-step fractions test the
    // largest weights.
    write_pixel(0, 0, 16'sh7FFF);
    write_pixel(0, 1, 16'sh8000);
    write_pixel(1, 0, 16'sh8000);
    write_pixel(1, 1, 16'sh7FFF);
    sample_at(16'h0000, 16'h0000);
    sample_at(16'h0080, 16'h0000);
    sample_at(16'h0080, 16'h0080);
    sample_at(16'h00FF, 16'h00FF);
    // The last cell of the store is the largest one still inside.
    write_pixel(254, 254, -16'sd1);
    write_pixel(254, 255, 16'sd0);
    write_pixel(255, 254, 16'sd1);
    write_pixel(255, 255, 16'sh8000);
    sample_at(16'hFEFF, 16'hFEFF);
    sample_at(16'hFEFF, 16'h0001);
    // Past the last cell: maximum coordinates, column only, row only.
    sample_at(16'hFFFF, 16'hFFFF);
    sample_at(16'hFF00, 16'h0000);
    sample_at(16'h0000, 16'hFF80);

    phase_cols[7] = REG_W'($urandom_range(256, 2));
    phase_rows[7] = REG_W'($urandom_range(256, 2));
    phase_cols[8] = REG_W'($urandom_range(40, 2));
    phase_rows[8] = REG_W'($urandom_range(256, 200));
    for (int p = 0; p < NUM_PHASES; p++)
      run_phase(phase_cols[p], phase_rows[p], phase_idle[p], PHASE_BEATS);

    drain_results();
    $display("Covered %0d input beats: %0d samples, %0d of them inside the image.",
             beats_sent, samples_sent, inside_sent);
    $display("Used %0d register writes over %0d image sizes, clamped and degenerate ones too.",
             cfg_writes, NUM_PHASES);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timed out with %0d results still expected", $time, pending_results);
    $display("== FAIL ==");
    $finish;
  end

endmodule
